/* rtl/assert_macros.svh */
// assertion macros shared by the tachometer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/tpfr_pkg.sv */
// types and constants of the tachometer period filter
package tpfr_pkg;

    // register map
    localparam int ADDR_W = 4;
    localparam logic [ADDR_W-1:0] ADDR_LOW_BOUND  = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_HIGH_BOUND = 4'h4;
    localparam logic [ADDR_W-1:0] ADDR_TICKS_MIN  = 4'h8;

    // reset values of the registers
    localparam logic [31:0] LOW_BOUND_RST  = 32'd200;
    localparam logic [31:0] HIGH_BOUND_RST = 32'd200000;
    localparam logic [31:0] TICKS_MIN_RST  = 32'd60000000;

    // item modes
    localparam logic MODE_PULSE = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // divider: one quotient bit per step
    localparam int QUO_W     = 32;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [31:0] low_bound;
        logic [31:0] high_bound;
        logic [31:0] ticks_per_minute;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [QUO_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/tpfr_regs.sv */
// configuration registers behind the apb port
module tpfr_regs
    import tpfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_bound        <= LOW_BOUND_RST;
            cfg_reg.high_bound       <= HIGH_BOUND_RST;
            cfg_reg.ticks_per_minute <= TICKS_MIN_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr)
                ADDR_LOW_BOUND:  cfg_reg.low_bound        <= pwdata;
                ADDR_HIGH_BOUND: cfg_reg.high_bound       <= pwdata;
                ADDR_TICKS_MIN:  cfg_reg.ticks_per_minute <= pwdata;
                default:         ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (paddr)
            ADDR_LOW_BOUND:  prdata = cfg_reg.low_bound;
            ADDR_HIGH_BOUND: prdata = cfg_reg.high_bound;
            ADDR_TICKS_MIN:  prdata = cfg_reg.ticks_per_minute;
            default:         prdata = 32'd0;
        endcase
    end

endmodule

/* rtl/tpfr_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module tpfr_div
    import tpfr_pkg::*;
#(
    parameter int DIVISOR_W = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    input  logic [DIVISOR_W-1:0] divisor,
    output div_stat_t            stat,
    output logic [QUO_W-1:0]     quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0] div_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [QUO_W-1:0]     quo_reg;

    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;
    logic [DIVISOR_W-1:0] rem_next;
    logic                 last_step;

    // one shift-subtract step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[QUO_W-1]};
        diff      = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});
        rem_next  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        last_step = (cnt_reg == CNT_W'(DIV_STEPS - 1));
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= req.dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `ASSERT_NXT(a_start_busy, clk, rst_n, req.start, busy_reg, "divider did not start")
    `ASSERT_NXT(a_done_idle, clk, rst_n, done_reg && !req.start, !busy_reg, "busy after done")
    `ASSERT_IMP(a_done_excl, clk, rst_n, done_reg, !busy_reg, "done while busy")

endmodule

/* rtl/tachometer_period_filter_rpm.sv */
// top level of the tachometer period filter and speed calculation
// Usage:
//   Input stream s_*: one item per tachometer event. s_tuser is the mode
//   (0 pulse with period, 1 clear speed values), s_tdata the raw period in
//   ticks. Output stream m_*: one result item per input item with speed,
//   filtered period and pulse count in m_tdata, the speed-updated flag in
//   m_tuser. Configuration via the apb port: low bound, high bound and
//   ticks per minute at byte addresses 0, 4 and 8.
// Sequencing:
//   An item that updates the speed runs the 32-step iterative divider; its
//   quotient goes into the speed register and then, in ST_DONE, into the
//   output register once that is free. Other items go from ST_IDLE straight
//   to ST_DONE. No new item is taken until the last one has left ST_DONE:
//   s_tready is high only while no item is in work.
// Reset clears filtered period, speed, pulse count and the output valid,
// and loads the register defaults.
// A stalled receiver holds the result in the output register; one more item
// is accepted meanwhile and its result waits until the register is taken.
`include "assert_macros.svh"
module tachometer_period_filter_rpm
    import tpfr_pkg::*;
#(
    parameter int PERIOD_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    // input items
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] period_ticks
    input  logic              s_tuser,   // [0] mode
    // result items
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [95:0]       m_tdata,   // [31:0] speed_rpm, [63:32] smoothed_period,
                                         // [95:64] pulse_total
    output logic              m_tuser,   // [0] in_range
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int RAW_W = (PERIOD_BITS < 32) ? PERIOD_BITS : 32;
    localparam logic [32:0] LIM_W = (33'd1 << RAW_W) - 33'd1;
    localparam logic [31:0] RAW_LIM = LIM_W[31:0];

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] smooth_reg;
    logic [31:0] speed_reg;
    logic [31:0] pulse_reg;
    logic        upd_reg;
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;
    logic        m_tuser_reg;

    cfg_t        cfg;
    div_req_t    div_req;
    div_stat_t   div_stat;
    logic [QUO_W-1:0] quotient;

    logic        accept;
    logic [31:0] raw_sat;
    logic [33:0] filt_sum;
    logic [31:0] smooth_new;
    logic        in_rng;
    logic        out_free;

    // configuration registers
    tpfr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // divider for the speed calculation
    tpfr_div #(
        .DIVISOR_W (RAW_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .divisor  (raw_sat[RAW_W-1:0]),
        .stat     (div_stat),
        .quotient (quotient)
    );

    // filter and range check on the incoming item
    always_comb
    begin
        raw_sat    = (s_tdata > RAW_LIM) ? RAW_LIM : s_tdata;
        filt_sum   = {2'b00, raw_sat} + {1'b0, smooth_reg, 1'b0} + {2'b00, smooth_reg};
        smooth_new = filt_sum[33:2];
        in_rng     = (smooth_new > cfg.low_bound) && (smooth_new < cfg.high_bound)
                     && (raw_sat != 32'd0);
    end

    assign s_tready         = (state_reg == ST_IDLE);
    assign accept           = s_tvalid && s_tready;
    assign div_req.start    = accept && (s_tuser == MODE_PULSE) && in_rng;
    assign div_req.dividend = cfg.ticks_per_minute;
    assign out_free         = !m_tvalid_reg || m_tready;

    // sequencer, speed state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            smooth_reg   <= '0;
            speed_reg    <= '0;
            pulse_reg    <= '0;
            upd_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            // a taken result frees the register unless a new one loads now
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser == MODE_CLEAR)
                        begin
                            smooth_reg <= '0;
                            speed_reg  <= '0;
                            upd_reg    <= 1'b0;
                            state_reg  <= ST_DONE;
                        end
                        else
                        begin
                            smooth_reg <= smooth_new;
                            pulse_reg  <= pulse_reg + 32'd1;
                            upd_reg    <= in_rng;
                            state_reg  <= in_rng ? ST_DIV : ST_DONE;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        speed_reg <= quotient;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {pulse_reg, smooth_reg, speed_reg};
                        m_tuser_reg  <= upd_reg;
                        state_reg    <= ST_IDLE;
                    end
                    else if (m_tvalid_reg && m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_IMP(a_div_in_state, clk, rst_n, div_stat.busy, state_reg == ST_DIV, "busy off div")
    `ASSERT_IMP(a_ready_div_idle, clk, rst_n, s_tready, !div_stat.busy, "ready while dividing")
    `ASSERT_IMP(a_upd_bounds, clk, rst_n, m_tvalid_reg && m_tuser_reg,
        (m_tdata_reg[63:32] > cfg.low_bound) && (m_tdata_reg[63:32] < cfg.high_bound),
        "speed update out of bounds")

endmodule

/* dv/tachometer_result_checker.sv */
// result predictor and checker for the tachometer period filter
module tachometer_result_checker
    import tpfr_pkg::*;
#(
    parameter int PERIOD_BITS = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [31:0]       s_tdata,   // [31:0] period_ticks
    input  logic              s_tuser,   // [0] mode
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [95:0]       m_tdata,   // [31:0] speed_rpm, [63:32] smoothed_period,
                                         // [95:64] pulse_total
    input  logic              m_tuser,   // [0] in_range
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] speed_rpm;
        logic [31:0] smoothed_period;
        logic [31:0] pulse_total;
        logic        in_range;
    } tach_result_t;

    // largest raw period the block can represent
    localparam logic [31:0] RAW_LIMIT =
        (PERIOD_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PERIOD_BITS) - 64'd1);

    // register copies
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    logic [31:0] ticks_per_minute;

    // speed state as the block should hold it
    logic [31:0] filt_period;
    logic [31:0] held_rpm;
    logic [31:0] pulse_count;

    tach_result_t expected_results[$];
    int fails  = 0;
    int queued = 0;

    assign fail_count = fails;
    assign pending    = queued;

    // advance the speed state by one item and return its result
    function automatic tach_result_t advance_tachometer(input logic mode,
                                                        input logic [31:0] ticks);
        tach_result_t res;
        logic [33:0]  sum;
        logic [31:0]  raw;
        res.in_range = 1'b0;
        if (mode == MODE_CLEAR) begin
            filt_period = '0;
            held_rpm    = '0;
        end
        else begin
            raw = (ticks > RAW_LIMIT) ? RAW_LIMIT : ticks;
            // iir filter: (raw + 3*old) / 4, rounded down
            sum = {2'b00, raw} + 34'd3 * {2'b00, filt_period};
            filt_period = sum[33:2];
            // speed only moves inside the open window and for a nonzero period
            if (filt_period > low_bound && filt_period < high_bound && raw != '0)
            begin
                held_rpm     = ticks_per_minute / raw;
                res.in_range = 1'b1;
            end
            pulse_count = pulse_count + 32'd1;
        end
        res.speed_rpm       = held_rpm;
        res.smoothed_period = filt_period;
        res.pulse_total     = pulse_count;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endfunction

    // watch all three ports at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        tach_result_t want;
        if (!rst_n)
        begin
            low_bound        = LOW_BOUND_RST;
            high_bound       = HIGH_BOUND_RST;
            ticks_per_minute = TICKS_MIN_RST;
            filt_period      = '0;
            held_rpm         = '0;
            pulse_count      = '0;
            expected_results.delete();
            queued = 0;
        end
        else
        begin
            // compare a taken result item with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no item waiting for it");
                    fails++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("speed_rpm", want.speed_rpm, m_tdata[31:0]);
                    check_field("smoothed_period", want.smoothed_period, m_tdata[63:32]);
                    check_field("pulse_total", want.pulse_total, m_tdata[95:64]);
                    check_field("in_range", {31'd0, want.in_range}, {31'd0, m_tuser});
                end
            end
            // predict for an accepted input item
            if (s_tvalid && s_tready)
                expected_results.push_back(advance_tachometer(s_tuser, s_tdata));
            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    ADDR_LOW_BOUND:  low_bound        = pwdata;
                    ADDR_HIGH_BOUND: high_bound       = pwdata;
                    ADDR_TICKS_MIN:  ticks_per_minute = pwdata;
                    default: ;
                endcase
            end
            queued = expected_results.size();
        end
    end

endmodule

/* dv/tb_tachometer_period_filter_rpm.sv */
// testbench top for the tachometer period filter: stimulus, register setup and verdict
module tb_tachometer_period_filter_rpm;
    timeunit 1ns;
    timeprecision 1ps;
    import tpfr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;   // [31:0] period_ticks
    logic              s_tuser  = 1'b0; // [0] mode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [95:0]       m_tdata;         // [31:0] speed_rpm, [63:32] smoothed_period,
                                        // [95:64] pulse_total
    logic              m_tuser;         // [0] in_range
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [31:0]       pwdata   = '0;
    logic [31:0]       prdata;
    logic              pready;

    int   fail_count;
    int   pending;
    int   cycles     = 0;
    int   stall_left = 0;
    logic calm       = 1'b0;

    tachometer_period_filter_rpm u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tachometer_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 2 ns clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_tachometer_period_filter_rpm failed");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(1, 16) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // offer one item, with an optional idle burst first
    task automatic send_item(input logic mode, input logic [31:0] ticks);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= ticks;
        do @(posedge clk); while (!s_tready);
    endtask

    // hold off until every outstanding result item has been taken
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // register write: setup then access cycle
    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_speed_window(input logic [31:0] lo, input logic [31:0] hi,
                                    input logic [31:0] tpm);
        wait_drained();
        reg_write(ADDR_LOW_BOUND, lo);
        reg_write(ADDR_HIGH_BOUND, hi);
        reg_write(ADDR_TICKS_MIN, tpm);
    endtask

    // trains of pulses around a base period so the filter settles, mixed with
    // clears, zero periods and full-range noise
    task automatic run_pulse_trains(input int n_items, input logic [31:0] lo,
                                    input logic [31:0] hi, input bit log_spread);
        int sent;
        int train;
        int pick;
        longint unsigned base;
        longint unsigned jit;
        longint unsigned val;
        sent = 0;
        while (sent < n_items)
        begin
            if (log_spread)
                base = $urandom >> $urandom_range(0, 31);
            else
                base = $urandom_range(lo, hi);
            jit   = base >> 4;
            train = $urandom_range(4, 30);
            for (int i = 0; i < train && sent < n_items; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_item(MODE_CLEAR, $urandom);
                else if (pick < 7)
                    send_item(MODE_PULSE, 32'd0);
                else if (pick < 10)
                    send_item(MODE_PULSE, $urandom);
                else if (pick < 11)
                    send_item(MODE_PULSE, 32'hFFFF_FFFF);
                else
                begin
                    val = base - jit + $urandom_range(0, 32'(2 * jit));
                    if (val > 64'hFFFF_FFFF)
                        val = 64'hFFFF_FFFF;
                    send_item(MODE_PULSE, val[31:0]);
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [31:0] lo;
        logic [31:0] hi;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: register defaults
        send_item(MODE_PULSE, 32'd0);
        send_item(MODE_PULSE, 32'hFFFF_FFFF);
        send_item(MODE_CLEAR, 32'd12345);
        repeat (5) send_item(MODE_PULSE, 32'd1000);
        send_item(MODE_PULSE, 32'd0);         // zero period inside the window
        send_item(MODE_PULSE, 32'd200);
        send_item(MODE_PULSE, 32'd199999);
        send_item(MODE_CLEAR, 32'hFFFF_FFFF);

        // widest window and largest numerator
        set_speed_window(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_PULSE, 32'd1);
        send_item(MODE_PULSE, 32'd4);
        send_item(MODE_PULSE, 32'hFFFF_FFFF);
        send_item(MODE_PULSE, 32'hFFFF_FFFF);

        // zero numerator
        set_speed_window(LOW_BOUND_RST, HIGH_BOUND_RST, 32'd0);
        send_item(MODE_PULSE, 32'd1000);
        send_item(MODE_PULSE, 32'd1000);

        // windows with no room
        set_speed_window(32'hFFFF_FFFF, 32'd0, TICKS_MIN_RST);
        send_item(MODE_PULSE, 32'd1000);
        set_speed_window(32'd500, 32'd501, TICKS_MIN_RST);
        send_item(MODE_PULSE, 32'd2000);
        send_item(MODE_PULSE, 32'd2000);

        // random: defaults, with a full drain half way
        set_speed_window(LOW_BOUND_RST, HIGH_BOUND_RST, TICKS_MIN_RST);
        run_pulse_trains(175, 32'd100, 32'd250000, 1'b0);
        wait_drained();
        run_pulse_trains(175, 32'd100, 32'd250000, 1'b0);

        // random: widest window, periods over all magnitudes
        set_speed_window(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_pulse_trains(250, 32'd0, 32'hFFFF_FFFF, 1'b1);

        // random windows and numerators
        repeat (2)
        begin
            lo = $urandom_range(0, 5000);
            hi = lo + $urandom_range(2, 500000);
            set_speed_window(lo, hi, $urandom);
            run_pulse_trains(125, lo >> 1, hi + (hi >> 2), 1'b0);
        end

        // random: zero numerator, then an empty window
        set_speed_window(LOW_BOUND_RST, HIGH_BOUND_RST, 32'd0);
        run_pulse_trains(100, 32'd100, 32'd250000, 1'b0);
        set_speed_window(32'd1000, 32'd1001, TICKS_MIN_RST);
        run_pulse_trains(100, 32'd500, 32'd2000, 1'b0);

        // last part at full rate on both sides
        lo = $urandom_range(0, 2000);
        hi = lo + $urandom_range(2, 300000);
        set_speed_window(lo, hi, $urandom);
        calm = 1'b1;
        run_pulse_trains(300, lo >> 1, hi + (hi >> 2), 1'b0);

        wait_drained();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_tachometer_period_filter_rpm passed");
        else
            $display("tb_tachometer_period_filter_rpm failed");
        $finish;
    end

endmodule
